>>> rtl/core/dlp_pkg.sv
package dlp_pkg;

  localparam int unsigned RECORD_LEN = 17;
  localparam int unsigned CNT_W      = 5;
  localparam logic [CNT_W-1:0] COUNT_MAX = 5'd31;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UPPA   = 8'h41;
  localparam logic [7:0] CH_UPPZ   = 8'h5a;
  localparam logic [7:0] HIGH_BIT  = 8'h80;
  localparam logic [7:0] CH_DIR_D  = 8'h44 | HIGH_BIT;
  localparam logic [7:0] CH_DIR_I  = 8'h49 | HIGH_BIT;
  localparam logic [7:0] CH_DIR_R  = 8'h52 | HIGH_BIT;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_FILE = 2'd1,
    KIND_DIR  = 2'd2
  } entry_kind_t;

  typedef logic [RECORD_LEN-1:0][7:0] line_t;

  typedef struct packed {
    entry_kind_t entry_kind;
    logic        locked;
    logic [9:0]  sector_count;
    logic [63:0] name_bytes;
    logic [3:0]  name_length;
    logic [23:0] ext_bytes;
    logic [1:0]  ext_length;
  } result_t;

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= CH_UPPA) && (c <= CH_UPPZ);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic valid_char(input logic [7:0] c);
    return is_upper(c) || is_digit(c) || (c == CH_UNDER) || (c == CH_AT);
  endfunction

endpackage

>>> rtl/core/dlp_if.sv
interface dlp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       last_char;

  modport source (output valid, output char_in, output last_char, input ready);
  modport sink   (input valid, input char_in, input last_char, output ready);
endinterface

interface dlp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  entry_kind;
  logic        locked;
  logic [9:0]  sector_count;
  logic [63:0] name_bytes;
  logic [3:0]  name_length;
  logic [23:0] ext_bytes;
  logic [1:0]  ext_length;

  modport source (
    output valid, input ready,
    output entry_kind, output locked, output sector_count,
    output name_bytes, output name_length, output ext_bytes, output ext_length
  );
  modport sink (
    input valid, output ready,
    input entry_kind, input locked, input sector_count,
    input name_bytes, input name_length, input ext_bytes, input ext_length
  );
endinterface

>>> rtl/core/dlp_cell.sv
module dlp_cell (
  input  logic       clk,
  input  logic       shift_en,
  input  logic [7:0] d,
  output logic [7:0] q
);

  logic [7:0] byte_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= d;
    end
  end

  assign q = byte_r;

endmodule

>>> rtl/core/dlp_classify.sv
module dlp_classify import dlp_pkg::*; (
  input  line_t   cols,
  input  logic    len_ok,
  input  logic    folders_en,
  output result_t res
);

  logic        flag_mark;
  logic        ext_mark;
  logic        line_ok;
  logic [7:0]  name_keep;
  logic [2:0]  ext_keep;
  logic        name_ok;
  logic        ext_ok;
  logic [3:0]  name_len;
  logic [1:0]  ext_len;
  logic [63:0] name_pk;
  logic [23:0] ext_pk;
  logic [9:0]  sectors;
  logic [7:0]  c;

  always_comb begin
    flag_mark = folders_en && (cols[1] == CH_COLON);
    ext_mark  = folders_en && !flag_mark && (cols[10] == CH_DIR_D)
                && (cols[11] == CH_DIR_I) && (cols[12] == CH_DIR_R);
    line_ok   = len_ok && (cols[13] == CH_SPACE)
                && (flag_mark || ext_mark || (cols[1] == CH_SPACE));

    name_keep[7] = (cols[9] != CH_SPACE);
    for (int k = 6; k >= 0; k--) begin
      name_keep[k] = name_keep[k+1] || (cols[2+k] != CH_SPACE);
    end
    name_ok  = name_keep[0] && is_upper(cols[2]);
    name_len = '0;
    name_pk  = '0;
    for (int k = 0; k < 8; k++) begin
      if (name_keep[k]) begin
        name_len = name_len + 4'd1;
        name_pk[63-8*k -: 8] = cols[2+k];
        if (!valid_char(cols[2+k])) begin
          name_ok = 1'b0;
        end
      end
    end

    ext_keep[2] = (cols[12] != CH_SPACE);
    for (int k = 1; k >= 0; k--) begin
      ext_keep[k] = ext_keep[k+1] || (cols[10+k] != CH_SPACE);
    end
    ext_ok  = 1'b1;
    ext_len = '0;
    ext_pk  = '0;
    for (int k = 0; k < 3; k++) begin
      if (ext_keep[k]) begin
        ext_len = ext_len + 2'd1;
        ext_pk[23-8*k -: 8] = cols[10+k];
        if (!valid_char(cols[10+k])) begin
          ext_ok = 1'b0;
        end
      end
    end

    sectors = '0;
    for (int i = 14; i < RECORD_LEN; i++) begin
      c = cols[i];
      if (is_digit(c)) begin
        sectors = (sectors << 3) + (sectors << 1) + {6'd0, c[3:0]};
      end
    end
    c = cols[0];

    res = '0;
    if (line_ok && name_ok && (ext_mark || ext_ok)) begin
      res.entry_kind   = (ext_mark || flag_mark) ? KIND_DIR : KIND_FILE;
      res.locked       = (c == CH_STAR);
      res.sector_count = sectors;
      res.name_bytes   = name_pk;
      res.name_length  = name_len;
      if (!ext_mark) begin
        res.ext_bytes  = ext_pk;
        res.ext_length = ext_len;
      end
    end
  end

endmodule

>>> rtl/core/directory_line_parser_core.sv
// directory listing line parser
// in_ch carries one byte of a listing line per transfer (char_in), from
// column zero, with last_char high on the final byte of the line.
// out_ch carries one result per line, produced by the transfer of the last
// byte: entry kind, locked mark, sector count, trimmed name and extension.
// cfg_we/cfg_wdata write folders_enabled; write only while the block is idle.
// the first 17 bytes shift through a row of byte cells; later bytes only
// advance a saturating column count.
// the result is registered at the last byte's transfer and appears on out_ch
// in the following cycle. in_ch takes one byte per cycle while out_ch is
// not stalled; the combinational classifier feeds the output register.
// when out_ch stalls with a result held, in_ch ready drops until the result
// is taken; a transfer on out_ch frees the register in the same cycle.
// reset clears the column count, the output valid and folders_enabled;
// the byte cells hold no reset value.
module directory_line_parser_core import dlp_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  dlp_in_if.sink        in_ch,
  dlp_out_if.source     out_ch,
  input  logic          cfg_we,
  input  logic          cfg_wdata
);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             folders_en_r;
  logic             out_valid_r;
  result_t          res_r;
  result_t          res;
  logic             in_xfer;
  logic             shift_en;
  line_t            cells_q;
  line_t            view;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign shift_en    = in_xfer && (count_r < CNT_W'(RECORD_LEN));

  for (genvar i = 0; i < RECORD_LEN; i++) begin : g_cell
    logic [7:0] d;
    if (i == RECORD_LEN - 1) begin : g_head
      assign d = in_ch.char_in;
    end else begin : g_link
      assign d = cells_q[i+1];
    end
    dlp_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .d        (d),
      .q        (cells_q[i])
    );
    assign view[i] = shift_en ? d : cells_q[i];
  end

  dlp_classify u_classify (
    .cols       (view),
    .len_ok     (count_r >= CNT_W'(RECORD_LEN - 1)),
    .folders_en (folders_en_r),
    .res        (res)
  );

  always_comb begin
    count_nxt = count_r;
    if (in_xfer) begin
      if (in_ch.last_char) begin
        count_nxt = '0;
      end else if (count_r != COUNT_MAX) begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      folders_en_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cfg_we) begin
        folders_en_r <= cfg_wdata;
      end
      if (in_xfer && in_ch.last_char) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_ch.last_char) begin
      res_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.entry_kind   = res_r.entry_kind;
  assign out_ch.locked       = res_r.locked;
  assign out_ch.sector_count = res_r.sector_count;
  assign out_ch.name_bytes   = res_r.name_bytes;
  assign out_ch.name_length  = res_r.name_length;
  assign out_ch.ext_bytes    = res_r.ext_bytes;
  assign out_ch.ext_length   = res_r.ext_length;

endmodule

>>> verif/tb_directory_line_parser_core.sv
`timescale 1ns / 1ps

module tb_directory_line_parser_core;
  import dlp_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  typedef enum logic [1:0] {
    MARK_NONE,
    MARK_COLON,
    MARK_DIR_EXT
  } folder_mark_t;

  typedef struct {
    string   text;
    logic    folders;
    logic    dir_ext;
    logic    typed;
    result_t want;
  } line_row_t;

  typedef struct {
    logic    typed;
    result_t want;
  } listed_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic cfg_wdata;

  dlp_in_if  in_ch ();
  dlp_out_if out_ch ();

  directory_line_parser_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [7:0] line_buf [RECORD_LEN];
  logic [4:0] col_cnt = '0;
  logic       folders_on = 1'b0;

  result_t        pending_results[$];
  listed_result_t listed_results[$];
  line_row_t      dir_rows[$];

  int mismatches = 0;
  int results_seen = 0;
  int files_seen = 0;
  int dirs_seen = 0;
  int rejects_seen = 0;
  int locked_seen = 0;
  int bytes_sent = 0;
  int lines_sent = 0;
  int src_calm = 0;
  int sink_calm = 0;
  logic held_once = 1'b0;

  function automatic logic name_char_ok(input logic [7:0] c);
    return (c >= CH_UPPA && c <= CH_UPPZ) || (c >= CH_ZERO && c <= CH_NINE) ||
           c == CH_UNDER || c == CH_AT;
  endfunction

  // trailing spaces dropped, first char at the top of the field
  function automatic int trim_pack(input int first, input int width,
                                   output logic [63:0] bits_o);
    int n;
    n = width;
    bits_o = '0;
    while (n > 0 && line_buf[first + n - 1] == CH_SPACE) n--;
    for (int k = 0; k < n; k++) begin
      if (!name_char_ok(line_buf[first + k])) return -1;
      bits_o |= 64'(line_buf[first + k]) << (8 * (width - 1 - k));
    end
    return n;
  endfunction

  function automatic result_t classify_line();
    result_t      r;
    folder_mark_t mark;
    logic [63:0]  nm;
    logic [63:0]  ex;
    int           n;
    int           e;
    int           secs;
    r = '0;
    mark = MARK_NONE;
    ex = '0;
    e = 0;
    secs = 0;
    if (col_cnt < RECORD_LEN || line_buf[13] != CH_SPACE) return r;
    if (folders_on) begin
      if (line_buf[1] == CH_COLON) mark = MARK_COLON;
      else if (line_buf[10] == CH_DIR_D && line_buf[11] == CH_DIR_I &&
               line_buf[12] == CH_DIR_R) mark = MARK_DIR_EXT;
    end
    if (mark == MARK_NONE && line_buf[1] != CH_SPACE) return r;
    n = trim_pack(2, 8, nm);
    if (n <= 0) return r;
    if (nm[63:56] < CH_UPPA || nm[63:56] > CH_UPPZ) return r;
    for (int i = 14; i < RECORD_LEN; i++) begin
      if (line_buf[i] >= CH_ZERO && line_buf[i] <= CH_NINE)
        secs = secs * 10 + int'(line_buf[i] - CH_ZERO);
    end
    if (mark == MARK_DIR_EXT) begin
      r.entry_kind = KIND_DIR;
    end else begin
      e = trim_pack(10, 3, ex);
      if (e < 0) return r;
      r.entry_kind = (mark == MARK_COLON) ? KIND_DIR : KIND_FILE;
    end
    r.locked = (line_buf[0] == CH_STAR);
    r.sector_count = secs[9:0];
    r.name_bytes = nm;
    r.name_length = n[3:0];
    r.ext_bytes = ex[23:0];
    r.ext_length = e[1:0];
    return r;
  endfunction

  function automatic void take_byte(input logic [7:0] c, input logic last);
    if (col_cnt < RECORD_LEN) line_buf[col_cnt] = c;
    if (col_cnt != COUNT_MAX) col_cnt++;
    if (last) begin
      pending_results.push_back(classify_line());
      col_cnt = '0;
    end
  endfunction

  task automatic check_result(input result_t want, input result_t got);
    if (got.entry_kind != want.entry_kind) begin
      $error("entry_kind expected %0d got %0d", want.entry_kind, got.entry_kind);
      mismatches++;
    end
    if (got.locked != want.locked) begin
      $error("locked expected %0d got %0d", want.locked, got.locked);
      mismatches++;
    end
    if (got.sector_count != want.sector_count) begin
      $error("sector_count expected %0d got %0d", want.sector_count, got.sector_count);
      mismatches++;
    end
    if (got.name_bytes != want.name_bytes) begin
      $error("name_bytes expected %h got %h", want.name_bytes, got.name_bytes);
      mismatches++;
    end
    if (got.name_length != want.name_length) begin
      $error("name_length expected %0d got %0d", want.name_length, got.name_length);
      mismatches++;
    end
    if (got.ext_bytes != want.ext_bytes) begin
      $error("ext_bytes expected %h got %h", want.ext_bytes, got.ext_bytes);
      mismatches++;
    end
    if (got.ext_length != want.ext_length) begin
      $error("ext_length expected %0d got %0d", want.ext_length, got.ext_length);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : transfer_monitor
    result_t        got;
    result_t        want;
    listed_result_t listed;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.entry_kind = entry_kind_t'(out_ch.entry_kind);
      got.locked = out_ch.locked;
      got.sector_count = out_ch.sector_count;
      got.name_bytes = out_ch.name_bytes;
      got.name_length = out_ch.name_length;
      got.ext_bytes = out_ch.ext_bytes;
      got.ext_length = out_ch.ext_length;
      results_seen++;
      if (got.entry_kind == KIND_FILE) files_seen++;
      else if (got.entry_kind == KIND_DIR) dirs_seen++;
      else rejects_seen++;
      if (got.locked) locked_seen++;
      if (pending_results.size() == 0) begin
        $error("result transfer with no line pending");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (listed_results.size() != 0) begin
          listed = listed_results.pop_front();
          if (listed.typed) want = listed.want;
        end
        check_result(want, got);
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) take_byte(in_ch.char_in, in_ch.last_char);
  end

  function automatic logic [7:0] rand_name_char();
    int pick;
    pick = $urandom_range(0, 37);
    if (pick < 26) return CH_UPPA + 8'(pick);
    if (pick < 36) return CH_ZERO + 8'(pick - 26);
    if (pick == 36) return CH_UNDER;
    return CH_AT;
  endfunction

  function automatic byte_q_t make_line();
    byte_q_t q;
    int      pick;
    int      nlen;
    int      elen;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      nlen = $urandom_range(1, 40);
      repeat (nlen) q.push_back(8'($urandom));
      return q;
    end
    pick = $urandom_range(0, 9);
    q.push_back(pick < 5 ? CH_SPACE : (pick < 9 ? CH_STAR : 8'($urandom)));
    pick = $urandom_range(0, 9);
    q.push_back(pick < 6 ? CH_SPACE : (pick < 9 ? CH_COLON : 8'($urandom)));
    nlen = $urandom_range(1, 8);
    for (int k = 0; k < 8; k++) begin
      if (k >= nlen) q.push_back(CH_SPACE);
      else if (k == 0 && $urandom_range(0, 9) != 0)
        q.push_back(CH_UPPA + 8'($urandom_range(0, 25)));
      else q.push_back(rand_name_char());
    end
    if ($urandom_range(0, 11) == 0) q[2 + $urandom_range(0, 7)] = 8'($urandom);
    if ($urandom_range(0, 5) == 0) begin
      q.push_back(CH_DIR_D);
      q.push_back(CH_DIR_I);
      q.push_back(CH_DIR_R);
    end else begin
      elen = $urandom_range(0, 3);
      for (int k = 0; k < 3; k++) q.push_back(k < elen ? rand_name_char() : CH_SPACE);
      if ($urandom_range(0, 11) == 0) q[10 + $urandom_range(0, 2)] = 8'($urandom);
    end
    q.push_back($urandom_range(0, 14) == 0 ? 8'($urandom) : CH_SPACE);
    for (int k = 0; k < 3; k++) begin
      pick = $urandom_range(0, 9);
      q.push_back(pick < 7 ? CH_ZERO + 8'($urandom_range(0, 9)) :
                  (pick < 9 ? CH_SPACE : 8'($urandom)));
    end
    if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 25)) q.push_back(8'($urandom));
    if ($urandom_range(0, 9) == 0) begin
      nlen = $urandom_range(1, RECORD_LEN - 1);
      while (q.size() > nlen) void'(q.pop_back());
    end
    return q;
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic last);
    int gap;
    gap = 0;
    if (src_calm > 0) src_calm--;
    else if ($urandom_range(0, 31) == 0) src_calm = $urandom_range(20, 80);
    else gap = $urandom_range(0, 9);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.char_in <= c;
    in_ch.last_char <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_line(input byte_q_t q);
    foreach (q[k]) send_byte(q[k], k == q.size() - 1);
    lines_sent++;
  endtask

  // only between lines, once every result is back
  task automatic set_folders(input logic on);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_wdata <= on;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    folders_on = on;
  endtask

  function automatic void add_row(input string text, input logic folders,
                                  input logic dir_ext, input logic typed,
                                  input result_t want);
    line_row_t row;
    row.text = text;
    row.folders = folders;
    row.dir_ext = dir_ext;
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endfunction

  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held_once && results_seen >= 40) begin
        held_once = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      stall = 0;
      if (sink_calm > 0) sink_calm--;
      else if ($urandom_range(0, 15) == 0) sink_calm = $urandom_range(10, 30);
      else stall = $urandom_range(0, 9);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(out_ch.valid && out_ch.ready)) @(posedge clk);
    end
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : line_source
    byte_q_t        row_bytes;
    listed_result_t listed;
    int             budget;
    int             wait_cnt;
    in_ch.valid <= 1'b0;
    in_ch.char_in <= '0;
    in_ch.last_char <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= 1'b0;

    add_row("  README  TXT 012", 1'b0, 1'b0, 1'b1,
            result_t'{KIND_FILE, 1'b0, 10'd12, 64'h524541444d450000, 4'd6,
                      24'h545854, 2'd3});
    add_row({"* A       ", "    999"}, 1'b0, 1'b0, 1'b1,
            result_t'{KIND_FILE, 1'b1, 10'd999, 64'h4100000000000000, 4'd1,
                      24'h0, 2'd0});
    add_row("  ZZZZZZZZ___ 5A7", 1'b0, 1'b0, 1'b0, '0);
    add_row("  @BC     DOC 001", 1'b0, 1'b0, 1'b1, '0);
    add_row("  9ABC    DOC 001", 1'b0, 1'b0, 1'b1, '0);
    add_row("  A B     DOC 001", 1'b0, 1'b0, 1'b0, '0);
    add_row("  A@_09Z  E 9 100", 1'b0, 1'b0, 1'b0, '0);
    add_row("  NAME    TXTX001", 1'b0, 1'b0, 1'b1, '0);
    add_row("  NAME    TXT 00", 1'b0, 1'b0, 1'b1, '0);
    add_row("A", 1'b0, 1'b0, 1'b1, '0);
    add_row({" :FOLDER", "      ", "042"}, 1'b0, 1'b0, 1'b1, '0);
    add_row("  SUB     DIR 003", 1'b0, 1'b1, 1'b0, '0);
    add_row("  lower   TXT 001", 1'b0, 1'b0, 1'b0, '0);
    add_row({"  LONGLINEABC 123", "xxxxxxxxxxxxxxxxxxxxxxx"}, 1'b0, 1'b0, 1'b0, '0);
    add_row("  FILE    TXT    ", 1'b0, 1'b0, 1'b0, '0);
    add_row({" :FOLDER", "      ", "042"}, 1'b1, 1'b0, 1'b0, '0);
    add_row("*:PROJ    X_1 777", 1'b1, 1'b0, 1'b0, '0);
    add_row("  SUB     DIR 003", 1'b1, 1'b1, 1'b0, '0);
    add_row("*:SUB     DIR 003", 1'b1, 1'b1, 1'b0, '0);
    add_row("  PLAIN   COM 010", 1'b1, 1'b0, 1'b0, '0);
    add_row("x:BAD     TXT 001", 1'b1, 1'b0, 1'b0, '0);
    add_row(" !NAME    TXT 001", 1'b1, 1'b0, 1'b1, '0);
    add_row("  1SUB    DIR 003", 1'b1, 1'b1, 1'b0, '0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_folders(1'b0);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].folders != folders_on) set_folders(dir_rows[r].folders);
      row_bytes = {};
      for (int k = 0; k < dir_rows[r].text.len(); k++)
        row_bytes.push_back(dir_rows[r].text[k]);
      if (dir_rows[r].dir_ext) begin
        row_bytes[10] = CH_DIR_D;
        row_bytes[11] = CH_DIR_I;
        row_bytes[12] = CH_DIR_R;
      end
      listed.typed = dir_rows[r].typed;
      listed.want = dir_rows[r].want;
      listed_results.push_back(listed);
      send_line(row_bytes);
    end

    for (int ph = 0; ph < 4; ph++) begin
      set_folders(ph % 2 == 0);
      budget = 300;
      while (budget > 0) begin
        row_bytes = make_line();
        send_line(row_bytes);
        budget -= row_bytes.size();
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait_cnt = 0;
    while (pending_results.size() != 0 && wait_cnt < 2000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (5) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d line results never arrived", pending_results.size());
      mismatches++;
    end

    $display("%0d bytes in %0d lines, %0d results: %0d files, %0d dirs, %0d rejected",
             bytes_sent, lines_sent, results_seen, files_seen, dirs_seen, rejects_seen);
    $display("%0d locked entries, folder marks on and off, one long output stall",
             locked_seen);
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> files.f
rtl/core/dlp_pkg.sv
rtl/core/dlp_if.sv
rtl/core/dlp_cell.sv
rtl/core/dlp_classify.sv
rtl/core/directory_line_parser_core.sv
verif/tb_directory_line_parser_core.sv
